### sv/brb_pkg.sv
// Shared types, constants and helpers for the byte ring buffer span manager.
package brb_pkg;

    localparam int CAPACITY    = 4096;
    localparam int MAX_PEEK    = 64;
    localparam int QUEUE_DEPTH = 2;

    localparam int IDX_W  = $clog2(CAPACITY);
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int PK_W   = $clog2(MAX_PEEK + 1);
    localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    // fixed field widths of the beats
    localparam int KIND_W   = 3;
    localparam int AMOUNT_W = 13;
    localparam int OFFSET_W = 12;
    localparam int BYTE_W   = 8;
    localparam int WORD_W   = 16;

    // kind codes on the request channel
    localparam logic [KIND_W-1:0] KIND_WRITE  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_COMMIT = 3'd1;
    localparam logic [KIND_W-1:0] KIND_POP    = 3'd2;
    localparam logic [KIND_W-1:0] KIND_PEEK   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_WORD   = 3'd4;

    typedef enum logic [2:0] {
        OP_WRITE,
        OP_COMMIT,
        OP_POP,
        OP_PEEK,
        OP_WORD,
        OP_BAD
    } op_t;

    typedef enum logic [2:0] {
        BST_IDLE,
        BST_EMIT,
        BST_PEEK,
        BST_WLO,
        BST_WHI
    } bst_t;

    typedef struct packed {
        op_t                 op;
        logic [AMOUNT_W-1:0] amount;
        logic [OFFSET_W-1:0] offset;
        logic [BYTE_W-1:0]   data;
        logic                peek_long;
    } cmd_t;

    typedef struct packed {
        logic [CNT_W-1:0] wr;
        logic [CNT_W-1:0] rd;
    } span_t;

    // index + n, wrapped once at CAPACITY
    function automatic logic [IDX_W-1:0] advance(input logic [IDX_W-1:0] idx,
                                                 input logic [CNT_W-1:0] n);
        logic [CNT_W:0] s;
        s = {{(CNT_W + 1 - IDX_W){1'b0}}, idx} + {1'b0, n};
        if (s >= (CNT_W + 1)'(CAPACITY))
            s = s - (CNT_W + 1)'(CAPACITY);
        return s[IDX_W-1:0];
    endfunction

    function automatic span_t spans(input logic [IDX_W-1:0] ri,
                                    input logic [IDX_W-1:0] wi,
                                    input logic [CNT_W-1:0] fill);
        span_t r;
        if (fill == '0 || ri < wi)
        begin
            r.wr = CNT_W'(CAPACITY) - {{(CNT_W - IDX_W){1'b0}}, wi};
            r.rd = fill;
        end
        else
        begin
            r.wr = {{(CNT_W - IDX_W){1'b0}}, ri} - {{(CNT_W - IDX_W){1'b0}}, wi};
            r.rd = CNT_W'(CAPACITY) - {{(CNT_W - IDX_W){1'b0}}, ri};
        end
        return r;
    endfunction

endpackage

### sv/brb_ram.sv
// Generic single-write, single-read RAM with registered read data.
module brb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re)
            rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### sv/brb_front.sv
// Front end: accepts request beats, classifies the kind and queues commands.
module brb_front (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            req_valid,
    output logic                            req_stall,
    input  logic [brb_pkg::KIND_W-1:0]      kind,
    input  logic [brb_pkg::AMOUNT_W-1:0]    amount,
    input  logic [brb_pkg::OFFSET_W-1:0]    offset,
    input  logic [brb_pkg::BYTE_W-1:0]      data_in,
    output logic                            cmd_valid,
    output brb_pkg::cmd_t                   cmd,
    input  logic                            cmd_pop
);
    import brb_pkg::*;

    cmd_t              q_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;
    cmd_t              cls;
    logic              push;
    logic              pop;

    // classify
    always_comb
    begin
        cls.amount    = amount;
        cls.offset    = offset;
        cls.data      = data_in;
        cls.peek_long = amount > AMOUNT_W'(MAX_PEEK);
        case (kind)
            KIND_WRITE:  cls.op = OP_WRITE;
            KIND_COMMIT: cls.op = OP_COMMIT;
            KIND_POP:    cls.op = OP_POP;
            KIND_PEEK:   cls.op = OP_PEEK;
            KIND_WORD:   cls.op = OP_WORD;
            default:     cls.op = OP_BAD;
        endcase
    end

    assign req_stall = (cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign push      = req_valid && !req_stall;
    assign pop       = cmd_pop && cmd_valid;
    assign cmd_valid = (cnt_reg != '0);
    assign cmd       = q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            cnt_next = cnt_reg + 1'b1;
        else if (pop && !push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            q_reg[wr_ptr_reg] <= cls;
    end

endmodule

### sv/brb_back.sv
// Back end: holds the indices and fill, owns the byte store, executes commands.
module brb_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cmd_valid,
    input  brb_pkg::cmd_t                 cmd,
    output logic                          cmd_pop,
    output logic                          rsp_valid,
    input  logic                          rsp_stall,
    output logic                          ok,
    output logic [brb_pkg::BYTE_W-1:0]    data_out,
    output logic [brb_pkg::WORD_W-1:0]    word_out,
    output logic                          last,
    output logic [brb_pkg::CNT_W-1:0]     fill_level,
    output logic [brb_pkg::CNT_W-1:0]     writable_span,
    output logic [brb_pkg::CNT_W-1:0]     readable_span
);
    import brb_pkg::*;

    bst_t              state_reg, state_next;
    logic [IDX_W-1:0]  ri_reg, ri_next;
    logic [IDX_W-1:0]  wi_reg, wi_next;
    logic [CNT_W-1:0]  fill_reg, fill_next;
    logic              res_ok_reg, res_ok_next;
    logic              res_word_reg, res_word_next;
    logic [BYTE_W-1:0] lo_reg, lo_next;
    logic [IDX_W-1:0]  pk_addr_reg, pk_addr_next;
    logic [PK_W-1:0]   issue_left_reg, issue_left_next;
    logic [PK_W-1:0]   emit_left_reg, emit_left_next;
    logic              rd_pend_reg, rd_pend_next;

    logic              out_valid_reg;
    logic              ok_reg;
    logic [BYTE_W-1:0] data_reg;
    logic [WORD_W-1:0] word_reg;
    logic              last_reg;
    logic [CNT_W-1:0]  fill_out_reg;
    logic [CNT_W-1:0]  wspan_reg;
    logic [CNT_W-1:0]  rspan_reg;

    span_t             sp;
    logic [CNT_W-1:0]  free_cnt;
    logic              can_load;
    logic              load;
    logic              load_ok;
    logic [BYTE_W-1:0] load_data;
    logic [WORD_W-1:0] load_word;
    logic              load_last;
    bst_t              dec_target;
    logic              dec_ok;
    logic              peek_issue;

    logic              we;
    logic [IDX_W-1:0]  waddr;
    logic              re;
    logic [IDX_W-1:0]  raddr;
    logic [BYTE_W-1:0] rdata;

    brb_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (CAPACITY)
    ) u_store (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (cmd.data),
        .re    (re),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign sp       = spans(ri_reg, wi_reg, fill_reg);
    assign free_cnt = CNT_W'(CAPACITY) - fill_reg;
    assign can_load = !out_valid_reg || !rsp_stall;
    assign peek_issue = (state_reg == BST_PEEK) && (issue_left_reg != '0)
                        && (!rd_pend_reg || can_load);

    // decision on a fresh command
    always_comb
    begin
        dec_ok     = 1'b0;
        dec_target = BST_EMIT;
        case (cmd.op)
            OP_WRITE:  dec_ok = {{(CNT_W - OFFSET_W){1'b0}}, cmd.offset} < sp.wr;
            OP_COMMIT: dec_ok = cmd.amount <= free_cnt;
            OP_POP:    dec_ok = cmd.amount <= fill_reg;
            OP_PEEK:
            begin
                if (cmd.amount > fill_reg || cmd.peek_long)
                    dec_ok = 1'b0;
                else if (cmd.amount == '0)
                    dec_ok = 1'b1;
                else
                begin
                    dec_ok     = 1'b1;
                    dec_target = BST_PEEK;
                end
            end
            OP_WORD:
            begin
                if (fill_reg >= CNT_W'(2))
                begin
                    dec_ok     = 1'b1;
                    dec_target = BST_WLO;
                end
            end
            default:   dec_ok = 1'b0;
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BST_IDLE:
                if (cmd_valid)
                    state_next = dec_target;
            BST_EMIT:
                if (can_load)
                    state_next = BST_IDLE;
            BST_PEEK:
                if (load && emit_left_reg == PK_W'(1))
                    state_next = BST_IDLE;
            BST_WLO:
                state_next = BST_WHI;
            BST_WHI:
                state_next = BST_EMIT;
            default:
                state_next = BST_IDLE;
        endcase
    end

    // datapath controls
    always_comb
    begin
        cmd_pop         = 1'b0;
        ri_next         = ri_reg;
        wi_next         = wi_reg;
        fill_next       = fill_reg;
        res_ok_next     = res_ok_reg;
        res_word_next   = res_word_reg;
        lo_next         = lo_reg;
        pk_addr_next    = pk_addr_reg;
        issue_left_next = issue_left_reg;
        emit_left_next  = emit_left_reg;
        rd_pend_next    = rd_pend_reg;
        we              = 1'b0;
        waddr           = advance(wi_reg, {{(CNT_W - OFFSET_W){1'b0}}, cmd.offset});
        re              = 1'b0;
        raddr           = ri_reg;
        load            = 1'b0;
        load_ok         = 1'b0;
        load_data       = '0;
        load_word       = '0;
        load_last       = 1'b1;
        case (state_reg)
            BST_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop       = 1'b1;
                    res_ok_next   = dec_ok;
                    res_word_next = 1'b0;
                    if (dec_ok)
                    begin
                        case (cmd.op)
                            OP_WRITE:  we = 1'b1;
                            OP_COMMIT:
                            begin
                                wi_next   = advance(wi_reg, cmd.amount);
                                fill_next = fill_reg + cmd.amount;
                            end
                            OP_POP:
                            begin
                                ri_next   = advance(ri_reg, cmd.amount);
                                fill_next = fill_reg - cmd.amount;
                            end
                            OP_PEEK:
                            begin
                                pk_addr_next    = ri_reg;
                                issue_left_next = cmd.amount[PK_W-1:0];
                                emit_left_next  = cmd.amount[PK_W-1:0];
                                rd_pend_next    = 1'b0;
                            end
                            default: ;
                        endcase
                    end
                end
            end
            BST_EMIT:
            begin
                load      = can_load;
                load_ok   = res_ok_reg;
                load_word = res_word_reg ? {rdata, lo_reg} : '0;
            end
            BST_PEEK:
            begin
                load      = rd_pend_reg && can_load;
                load_ok   = 1'b1;
                load_data = rdata;
                load_last = (emit_left_reg == PK_W'(1));
                if (load)
                    emit_left_next = emit_left_reg - 1'b1;
                if (peek_issue)
                begin
                    re              = 1'b1;
                    raddr           = pk_addr_reg;
                    pk_addr_next    = advance(pk_addr_reg, CNT_W'(1));
                    issue_left_next = issue_left_reg - 1'b1;
                end
                rd_pend_next = peek_issue || (rd_pend_reg && !can_load);
            end
            BST_WLO:
            begin
                re    = 1'b1;
                raddr = ri_reg;
            end
            BST_WHI:
            begin
                lo_next       = rdata;
                re            = 1'b1;
                raddr         = advance(ri_reg, CNT_W'(1));
                res_word_next = 1'b1;
                res_ok_next   = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= BST_IDLE;
            ri_reg         <= '0;
            wi_reg         <= '0;
            fill_reg       <= '0;
            issue_left_reg <= '0;
            emit_left_reg  <= '0;
            rd_pend_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            ri_reg         <= ri_next;
            wi_reg         <= wi_next;
            fill_reg       <= fill_next;
            issue_left_reg <= issue_left_next;
            emit_left_reg  <= emit_left_next;
            rd_pend_reg    <= rd_pend_next;
            if (load)
                out_valid_reg <= 1'b1;
            else if (!rsp_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        res_ok_reg   <= res_ok_next;
        res_word_reg <= res_word_next;
        lo_reg       <= lo_next;
        pk_addr_reg  <= pk_addr_next;
        if (load)
        begin
            ok_reg       <= load_ok;
            data_reg     <= load_data;
            word_reg     <= load_word;
            last_reg     <= load_last;
            fill_out_reg <= fill_reg;
            wspan_reg    <= sp.wr;
            rspan_reg    <= sp.rd;
        end
    end

    assign rsp_valid     = out_valid_reg;
    assign ok            = ok_reg;
    assign data_out      = data_reg;
    assign word_out      = word_reg;
    assign last          = last_reg;
    assign fill_level    = fill_out_reg;
    assign writable_span = wspan_reg;
    assign readable_span = rspan_reg;

endmodule

### sv/byte_ring_buffer_span_manager.sv
// Top level of the byte ring buffer span manager: front end, command queue and back end.
//
// A 4096-byte circular buffer with a read index, a write index and a fill count.
// Each request beat carries one command (write byte at an offset past the write
// index, commit, pop, peek a run, read a little-endian word) and yields one or
// more response beats, the final one marked by last; every response reports the
// fill and the contiguous writable and readable spans after the command. Refused
// commands change nothing and answer with ok low. Request beats land in a
// two-entry command queue in the front end, so the requester is stalled only when
// that queue is full. The back end sequencer runs one command at a time: write,
// commit, pop and refused commands pass through dispatch and response; a word
// read passes through dispatch, two reads of the single read port of the byte
// store and response; a peek streams its bytes one byte a cycle through the store's
// registered read port when the response side does not stall. The response
// register lets the back end move on while a finished beat waits. The byte store
// has no reset: reading bytes that were never written gives undefined data.
module byte_ring_buffer_span_manager (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            req_valid,
    output logic                            req_stall,
    input  logic [brb_pkg::KIND_W-1:0]      kind,
    input  logic [brb_pkg::AMOUNT_W-1:0]    amount,
    input  logic [brb_pkg::OFFSET_W-1:0]    offset,
    input  logic [brb_pkg::BYTE_W-1:0]      data_in,
    output logic                            rsp_valid,
    input  logic                            rsp_stall,
    output logic                            ok,
    output logic [brb_pkg::BYTE_W-1:0]      data_out,
    output logic [brb_pkg::WORD_W-1:0]      word_out,
    output logic                            last,
    output logic [brb_pkg::CNT_W-1:0]       fill_level,
    output logic [brb_pkg::CNT_W-1:0]       writable_span,
    output logic [brb_pkg::CNT_W-1:0]       readable_span
);
    import brb_pkg::*;

    // front to back: queued command and its pop strobe
    logic cmd_valid;
    cmd_t cmd;
    logic cmd_pop;

    brb_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .kind      (kind),
        .amount    (amount),
        .offset    (offset),
        .data_in   (data_in),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop)
    );

    // back end holds all buffer state; the response register lives here too
    brb_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd_valid     (cmd_valid),
        .cmd           (cmd),
        .cmd_pop       (cmd_pop),
        .rsp_valid     (rsp_valid),
        .rsp_stall     (rsp_stall),
        .ok            (ok),
        .data_out      (data_out),
        .word_out      (word_out),
        .last          (last),
        .fill_level    (fill_level),
        .writable_span (writable_span),
        .readable_span (readable_span)
    );

endmodule

### tb/brb_checker.sv
// Response checker for the byte ring buffer: predicts every response beat and compares.
module brb_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         req_valid,
    input  logic                         req_stall,
    input  logic [brb_pkg::KIND_W-1:0]   kind,
    input  logic [brb_pkg::AMOUNT_W-1:0] amount,
    input  logic [brb_pkg::OFFSET_W-1:0] offset,
    input  logic [brb_pkg::BYTE_W-1:0]   data_in,
    input  logic                         rsp_valid,
    input  logic                         rsp_stall,
    input  logic                         ok,
    input  logic [brb_pkg::BYTE_W-1:0]   data_out,
    input  logic [brb_pkg::WORD_W-1:0]   word_out,
    input  logic                         last,
    input  logic [brb_pkg::CNT_W-1:0]    fill_level,
    input  logic [brb_pkg::CNT_W-1:0]    writable_span,
    input  logic [brb_pkg::CNT_W-1:0]    readable_span,
    output int                           mismatch_count,
    output int                           pending_beats,
    output logic [brb_pkg::IDX_W-1:0]    ring_rd_idx,
    output logic [brb_pkg::IDX_W-1:0]    ring_wr_idx,
    output logic [brb_pkg::CNT_W-1:0]    ring_fill,
    output logic [brb_pkg::CNT_W-1:0]    ring_wr_span
);
    import brb_pkg::*;

    typedef struct packed {
        logic              ok;
        logic [BYTE_W-1:0] data;
        logic [WORD_W-1:0] word;
        logic              last;
        logic [CNT_W-1:0]  fill;
        logic [CNT_W-1:0]  wspan;
        logic [CNT_W-1:0]  rspan;
    } rsp_beat_t;

    logic [BYTE_W-1:0] store [0:CAPACITY-1];
    logic [IDX_W-1:0]  rd_idx;
    logic [IDX_W-1:0]  wr_idx;
    logic [CNT_W-1:0]  fill;
    rsp_beat_t         expected_beats[$];

    function automatic logic [CNT_W-1:0] wr_span_now();
        if (fill == '0 || rd_idx < wr_idx)
            return CNT_W'(CAPACITY - int'(wr_idx));
        return CNT_W'(int'(rd_idx) - int'(wr_idx));
    endfunction

    function automatic logic [CNT_W-1:0] rd_span_now();
        if (fill == '0 || rd_idx < wr_idx)
            return fill;
        return CNT_W'(CAPACITY - int'(rd_idx));
    endfunction

    function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] idx, input int n);
        int s;
        s = int'(idx) + n;
        if (s >= CAPACITY)
            s = s - CAPACITY;
        return IDX_W'(s);
    endfunction

    // spans and fill are taken after the state change of the command
    task automatic queue_beat(input logic okv, input logic [BYTE_W-1:0] d,
                              input logic [WORD_W-1:0] w, input logic lst);
        rsp_beat_t b;
        b.ok    = okv;
        b.data  = d;
        b.word  = w;
        b.last  = lst;
        b.fill  = fill;
        b.wspan = wr_span_now();
        b.rspan = rd_span_now();
        expected_beats.push_back(b);
    endtask

    task automatic predict_request(input logic [KIND_W-1:0] k, input logic [AMOUNT_W-1:0] amt,
                                   input logic [OFFSET_W-1:0] off, input logic [BYTE_W-1:0] din);
        int n;
        int i;
        n = int'(amt);
        case (k)
            KIND_WRITE:
            begin
                if (int'(off) < int'(wr_span_now()))
                begin
                    store[ring_add(wr_idx, int'(off))] = din;
                    queue_beat(1'b1, '0, '0, 1'b1);
                end
                else
                    queue_beat(1'b0, '0, '0, 1'b1);
            end
            KIND_COMMIT:
            begin
                if (n > CAPACITY - int'(fill))
                    queue_beat(1'b0, '0, '0, 1'b1);
                else
                begin
                    fill   = CNT_W'(int'(fill) + n);
                    wr_idx = ring_add(wr_idx, n);
                    queue_beat(1'b1, '0, '0, 1'b1);
                end
            end
            KIND_POP:
            begin
                if (n > int'(fill))
                    queue_beat(1'b0, '0, '0, 1'b1);
                else
                begin
                    fill   = CNT_W'(int'(fill) - n);
                    rd_idx = ring_add(rd_idx, n);
                    queue_beat(1'b1, '0, '0, 1'b1);
                end
            end
            KIND_PEEK:
            begin
                if (n > int'(fill) || n > MAX_PEEK)
                    queue_beat(1'b0, '0, '0, 1'b1);
                else if (n == 0)
                    queue_beat(1'b1, '0, '0, 1'b1);
                else
                begin
                    for (i = 0; i < n; i++)
                        queue_beat(1'b1, store[ring_add(rd_idx, i)], '0, i == n - 1);
                end
            end
            KIND_WORD:
            begin
                if (int'(fill) < 2)
                    queue_beat(1'b0, '0, '0, 1'b1);
                else
                    queue_beat(1'b1, '0, {store[ring_add(rd_idx, 1)], store[rd_idx]}, 1'b1);
            end
            default:
                queue_beat(1'b0, '0, '0, 1'b1);
        endcase
    endtask

    function automatic bit field_matches(input string name, input logic [WORD_W-1:0] exp_v,
                                         input logic [WORD_W-1:0] act_v);
        if (act_v === exp_v)
            return 1'b1;
        $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, exp_v, act_v);
        return 1'b0;
    endfunction

    always @(posedge clk)
    begin
        rsp_beat_t want;
        bit        good;
        if (!rst_n)
        begin
            rd_idx = '0;
            wr_idx = '0;
            fill   = '0;
            expected_beats.delete();
            mismatch_count = 0;
        end
        else
        begin
            // check before predicting, so a stray beat never meets a fresh expectation
            if (rsp_valid && !rsp_stall)
            begin
                if (expected_beats.size() == 0)
                begin
                    $display("%0t: unexpected beat: expected none, actual ok=%0h data=%0h word=%0h",
                             $time, ok, data_out, word_out);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_beats.pop_front();
                    good = 1'b1;
                    good &= field_matches("ok", want.ok, ok);
                    good &= field_matches("data_out", want.data, data_out);
                    good &= field_matches("word_out", want.word, word_out);
                    good &= field_matches("last", want.last, last);
                    good &= field_matches("fill_level", want.fill, fill_level);
                    good &= field_matches("writable_span", want.wspan, writable_span);
                    good &= field_matches("readable_span", want.rspan, readable_span);
                    if (!good)
                        mismatch_count++;
                end
            end
            if (req_valid && !req_stall)
                predict_request(kind, amount, offset, data_in);
        end
        pending_beats = expected_beats.size();
        ring_rd_idx   = rd_idx;
        ring_wr_idx   = wr_idx;
        ring_fill     = fill;
        ring_wr_span  = wr_span_now();
    end

endmodule

### tb/tb.sv
// Testbench top for the byte ring buffer span manager: stimulus, stalls and verdict.
module tb;
    import brb_pkg::*;

    localparam int RANDOM_ITEMS = 124;
    localparam int DRAIN_CYCLES = 16;
    localparam int RUN_LIMIT    = 10_000_000;
    localparam int AMOUNT_MAX   = (1 << AMOUNT_W) - 1;

    // reserved kind codes, ignored by the block
    localparam logic [KIND_W-1:0] KIND_RSVD_LO = 3'd5;
    localparam logic [KIND_W-1:0] KIND_RSVD_HI = 3'd7;

    typedef enum int {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY
    } stall_mode_t;

    logic                clk;
    logic                rst_n;
    logic                req_valid;
    logic                req_stall;
    logic [KIND_W-1:0]   kind;
    logic [AMOUNT_W-1:0] amount;
    logic [OFFSET_W-1:0] offset;
    logic [BYTE_W-1:0]   data_in;
    logic                rsp_valid;
    logic                rsp_stall;
    logic                ok;
    logic [BYTE_W-1:0]   data_out;
    logic [WORD_W-1:0]   word_out;
    logic                last;
    logic [CNT_W-1:0]    fill_level;
    logic [CNT_W-1:0]    writable_span;
    logic [CNT_W-1:0]    readable_span;

    int                  mismatch_count;
    int                  pending_beats;
    logic [IDX_W-1:0]    ring_rd_idx;
    logic [IDX_W-1:0]    ring_wr_idx;
    logic [CNT_W-1:0]    ring_fill;
    logic [CNT_W-1:0]    ring_wr_span;

    // Store entries that have held a byte at some point. Peeks and word reads
    // are only aimed at stored bytes, as unwritten entries read back undefined.
    bit                  stored_once [0:CAPACITY-1];
    int                  items_sent;
    int                  burst_left;
    stall_mode_t         stall_mode;
    int                  stall_phase_left;

    byte_ring_buffer_span_manager dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (req_valid),
        .req_stall     (req_stall),
        .kind          (kind),
        .amount        (amount),
        .offset        (offset),
        .data_in       (data_in),
        .rsp_valid     (rsp_valid),
        .rsp_stall     (rsp_stall),
        .ok            (ok),
        .data_out      (data_out),
        .word_out      (word_out),
        .last          (last),
        .fill_level    (fill_level),
        .writable_span (writable_span),
        .readable_span (readable_span)
    );

    // Watches both channels, predicts and compares; also exports its view of
    // the indices so the stimulus can aim at interesting places.
    brb_checker rsp_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .req_valid      (req_valid),
        .req_stall      (req_stall),
        .kind           (kind),
        .amount         (amount),
        .offset         (offset),
        .data_in        (data_in),
        .rsp_valid      (rsp_valid),
        .rsp_stall      (rsp_stall),
        .ok             (ok),
        .data_out       (data_out),
        .word_out       (word_out),
        .last           (last),
        .fill_level     (fill_level),
        .writable_span  (writable_span),
        .readable_span  (readable_span),
        .mismatch_count (mismatch_count),
        .pending_beats  (pending_beats),
        .ring_rd_idx    (ring_rd_idx),
        .ring_wr_idx    (ring_wr_idx),
        .ring_fill      (ring_fill),
        .ring_wr_span   (ring_wr_span)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // hard stop in case the block hangs
    initial
    begin
        #(RUN_LIMIT);
        $display("FAILED: results differ");
        $finish;
    end

    // Response side: stall pattern in phases - none, light, heavy - each
    // lasting a random number of cycles.
    initial
        rsp_stall = 1'b0;

    always @(negedge clk)
    begin
        if (stall_phase_left == 0)
        begin
            stall_mode       = stall_mode_t'($urandom_range(0, 2));
            stall_phase_left = $urandom_range(20, 80);
        end
        stall_phase_left--;
        case (stall_mode)
            STALL_NONE:  rsp_stall <= 1'b0;
            STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
            default:     rsp_stall <= ($urandom_range(0, 4) != 0);
        endcase
    end

    // random bits for fields that the command does not use
    function automatic int noise_val(input int w);
        return int'($urandom & ((32'd1 << w) - 32'd1));
    endfunction

    // length of the run of stored entries from start, capped at limit
    function automatic int stored_run(input int start, input int limit);
        int n;
        n = 0;
        while (n < limit && stored_once[(start + n) % CAPACITY])
            n++;
        return n;
    endfunction

    // Entered and left just after a falling edge, so the checker's view of the
    // ring already holds every accepted beat. The sender runs in bursts of
    // random length; a gap of zero keeps valid high straight through.
    task automatic send_item(input logic [KIND_W-1:0] k, input int amt, input int off,
                             input int din);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
            if (gap > 0)
            begin
                req_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        // a write that lands inside the writable span stores its byte
        if (k == KIND_WRITE && off < int'(ring_wr_span))
            stored_once[(int'(ring_wr_idx) + off) % CAPACITY] = 1'b1;
        req_valid <= 1'b1;
        kind      <= k;
        amount    <= AMOUNT_W'(amt);
        offset    <= OFFSET_W'(off);
        data_in   <= BYTE_W'(din);
        do
            @(posedge clk);
        while (req_stall);
        @(negedge clk);
        items_sent++;
    endtask

    initial
    begin
        int sel;
        int n;
        int j;
        int free;
        int run;
        int lim;
        int amt;
        int random_start;

        rst_n            = 1'b0;
        req_valid        = 1'b0;
        kind             = KIND_WRITE;
        amount           = '0;
        offset           = '0;
        data_in          = '0;
        items_sent       = 0;
        burst_left       = 0;
        stall_phase_left = 0;
        stall_mode       = STALL_NONE;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // ---- directed part ----
        // empty buffer: short-fill word, empty peek, peek past the fill, pop past the fill
        send_item(KIND_WORD, noise_val(AMOUNT_W), noise_val(OFFSET_W), noise_val(BYTE_W));
        send_item(KIND_PEEK, 0, noise_val(OFFSET_W), noise_val(BYTE_W));
        send_item(KIND_PEEK, 1, noise_val(OFFSET_W), noise_val(BYTE_W));
        send_item(KIND_POP, 1, noise_val(OFFSET_W), noise_val(BYTE_W));
        // byte writes at the lowest and highest offsets, extreme data
        send_item(KIND_WRITE, noise_val(AMOUNT_W), 0, 8'hA5);
        send_item(KIND_WRITE, noise_val(AMOUNT_W), CAPACITY - 1, 8'hFF);
        send_item(KIND_WRITE, noise_val(AMOUNT_W), 1, 8'h00);
        // commit far too large, zero-length commit, then a real one
        send_item(KIND_COMMIT, AMOUNT_MAX, noise_val(OFFSET_W), noise_val(BYTE_W));
        send_item(KIND_COMMIT, 0, noise_val(OFFSET_W), noise_val(BYTE_W));
        send_item(KIND_COMMIT, 2, noise_val(OFFSET_W), noise_val(BYTE_W));
        send_item(KIND_WORD, noise_val(AMOUNT_W), noise_val(OFFSET_W), noise_val(BYTE_W));
        send_item(KIND_POP, 2, noise_val(OFFSET_W), noise_val(BYTE_W));
        // full buffer: no write space, peek over the cap; nothing here reads bytes
        send_item(KIND_COMMIT, CAPACITY, noise_val(OFFSET_W), noise_val(BYTE_W));
        send_item(KIND_WRITE, noise_val(AMOUNT_W), 0, noise_val(BYTE_W));
        send_item(KIND_PEEK, MAX_PEEK + 1, noise_val(OFFSET_W), noise_val(BYTE_W));
        send_item(KIND_POP, CAPACITY, noise_val(OFFSET_W), noise_val(BYTE_W));
        // ignored kinds
        send_item(KIND_RSVD_LO, noise_val(AMOUNT_W), noise_val(OFFSET_W), noise_val(BYTE_W));
        send_item(KIND_RSVD_HI, noise_val(AMOUNT_W), noise_val(OFFSET_W), noise_val(BYTE_W));
        // walk both indices to the last entry, then straddle the wrap
        send_item(KIND_COMMIT, CAPACITY - 3, noise_val(OFFSET_W), noise_val(BYTE_W));
        send_item(KIND_POP, CAPACITY - 3, noise_val(OFFSET_W), noise_val(BYTE_W));
        send_item(KIND_WRITE, noise_val(AMOUNT_W), 0, 8'h3C);
        send_item(KIND_COMMIT, 1, noise_val(OFFSET_W), noise_val(BYTE_W));
        send_item(KIND_WRITE, noise_val(AMOUNT_W), 0, 8'h5A);
        send_item(KIND_COMMIT, 1, noise_val(OFFSET_W), noise_val(BYTE_W));
        send_item(KIND_WORD, noise_val(AMOUNT_W), noise_val(OFFSET_W), noise_val(BYTE_W));
        send_item(KIND_PEEK, 2, noise_val(OFFSET_W), noise_val(BYTE_W));

        // ---- random part ----
        // Mostly well-formed work: fill bursts followed by a commit, peeks and
        // word reads over stored bytes, pops. Skips commit unstored space and
        // pop everything at once to move the indices round the ring. The rest
        // is noise: refused commands and ignored kinds.
        random_start = items_sent;
        while (items_sent - random_start < RANDOM_ITEMS)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 30)
            begin
                n = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 72) : $urandom_range(1, 10);
                for (j = 0; j < n && j < int'(ring_wr_span); j++)
                    send_item(KIND_WRITE, noise_val(AMOUNT_W), j, noise_val(BYTE_W));
                free = CAPACITY - int'(ring_fill);
                run  = stored_run(int'(ring_wr_idx), free);
                amt  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, run) : run;
                send_item(KIND_COMMIT, amt, noise_val(OFFSET_W), noise_val(BYTE_W));
            end
            else if (sel < 50)
            begin
                run = stored_run(int'(ring_rd_idx), int'(ring_fill));
                lim = (run < MAX_PEEK) ? run : MAX_PEEK;
                send_item(KIND_PEEK, $urandom_range(0, lim), noise_val(OFFSET_W),
                          noise_val(BYTE_W));
            end
            else if (sel < 60)
            begin
                // a word read may only touch stored bytes; fall back to an empty peek
                if (int'(ring_fill) < 2 || stored_run(int'(ring_rd_idx), 2) == 2)
                    send_item(KIND_WORD, noise_val(AMOUNT_W), noise_val(OFFSET_W),
                              noise_val(BYTE_W));
                else
                    send_item(KIND_PEEK, 0, noise_val(OFFSET_W), noise_val(BYTE_W));
            end
            else if (sel < 75)
                send_item(KIND_POP, $urandom_range(0, int'(ring_fill)), noise_val(OFFSET_W),
                          noise_val(BYTE_W));
            else if (sel < 80)
            begin
                free = CAPACITY - int'(ring_fill);
                if (free > 0)
                begin
                    send_item(KIND_COMMIT, $urandom_range(1, free), noise_val(OFFSET_W),
                              noise_val(BYTE_W));
                    send_item(KIND_POP, int'(ring_fill), noise_val(OFFSET_W), noise_val(BYTE_W));
                end
            end
            else if (sel < 88)
                send_item(KIND_WRITE, noise_val(AMOUNT_W), noise_val(OFFSET_W), noise_val(BYTE_W));
            else
            begin
                free = CAPACITY - int'(ring_fill);
                case ($urandom_range(0, 3))
                    0: send_item(KIND_COMMIT, $urandom_range(free + 1, AMOUNT_MAX),
                                 noise_val(OFFSET_W), noise_val(BYTE_W));
                    1: send_item(KIND_POP, $urandom_range(int'(ring_fill) + 1, AMOUNT_MAX),
                                 noise_val(OFFSET_W), noise_val(BYTE_W));
                    2:
                    begin
                        // over the peek cap but within the fill, or beyond the fill
                        if (int'(ring_fill) > MAX_PEEK && $urandom_range(0, 1) == 1)
                            amt = $urandom_range(MAX_PEEK + 1, int'(ring_fill));
                        else
                            amt = $urandom_range(int'(ring_fill) + 1, AMOUNT_MAX);
                        send_item(KIND_PEEK, amt, noise_val(OFFSET_W), noise_val(BYTE_W));
                    end
                    default: send_item(KIND_W'($urandom_range(KIND_RSVD_LO, KIND_RSVD_HI)),
                                       noise_val(AMOUNT_W), noise_val(OFFSET_W),
                                       noise_val(BYTE_W));
                endcase
            end
        end

        // ---- wind down ----
        req_valid <= 1'b0;
        while (pending_beats != 0)
            @(negedge clk);
        // let any stray beat surface before the verdict
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mismatch_count == 0 && pending_beats == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
